FILE: hw/rtl/rthsv_pkg.sv
// Shared types and constants for the RGB to HSV pixel pipeline.
`default_nettype none

package rthsv_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned DIV_STEPS = 8;                    // quotient bits per divider
  localparam int unsigned REM_W     = 2 * CH_W;             // dividend / remainder width
  localparam int unsigned DIV_W     = CH_W + DIV_STEPS - 1; // divisor pre-shifted by 7
  localparam int unsigned NUM_W     = 14;                   // 43 * 255 fits in 14 bits

  localparam logic [5:0]      HUE_STEP  = 6'd43;
  localparam logic [CH_W-1:0] HUE_OFS_G = 8'd86;
  localparam logic [CH_W-1:0] HUE_OFS_B = 8'd172;
  localparam logic [CH_W-1:0] CH_MAX    = 8'hFF;

  typedef enum logic [1:0] {
    SECT_GREY  = 2'd0,
    SECT_RED   = 2'd1,
    SECT_GREEN = 2'd2,
    SECT_BLUE  = 2'd3
  } sector_e;

  // One pipeline slot: both dividers in flight plus side-band pixel data.
  typedef struct packed {
    logic                  vld;
    sector_e               sector;
    logic                  neg;
    logic [REM_W-1:0]      hrem;
    logic [DIV_W-1:0]      hdiv;
    logic [DIV_STEPS-1:0]  hq;
    logic [REM_W-1:0]      srem;
    logic [DIV_W-1:0]      sdiv;
    logic [DIV_STEPS-1:0]  sq;
    logic [CH_W-1:0]       val;
    logic [CH_W-1:0]       alpha;
  } slot_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rthsv_prep.sv
// First stage: max/min, sector select and divider operand setup.
`default_nettype none

module rthsv_prep (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic [7:0]            alpha_i,
  output rthsv_pkg::slot_t      slot_o
);
  import rthsv_pkg::*;

  logic [CH_W-1:0]  mx, mn, dlt, mag;
  logic [CH_W:0]    diff;
  sector_e          sect;
  logic [NUM_W-1:0] hnum;
  logic [REM_W-1:0] snum;
  slot_t            slot_d, slot_q;

  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    mx = (mx > blue_i) ? mx : blue_i;
    mn = (red_i < green_i) ? red_i : green_i;
    mn = (mn < blue_i) ? mn : blue_i;
    dlt = mx - mn;

    // red wins ties over green, green over blue
    if (dlt == '0) begin
      sect = SECT_GREY;
      diff = '0;
    end else if (mx == red_i) begin
      sect = SECT_RED;
      diff = {1'b0, green_i} - {1'b0, blue_i};
    end else if (mx == green_i) begin
      sect = SECT_GREEN;
      diff = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      sect = SECT_BLUE;
      diff = {1'b0, red_i} - {1'b0, green_i};
    end

    mag  = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
    hnum = NUM_W'(mag) * NUM_W'(HUE_STEP);
    snum = {dlt, {CH_W{1'b0}}} - REM_W'(dlt);   // dlt * 255

    slot_d.vld    = vld_i;
    slot_d.sector = sect;
    slot_d.neg    = diff[CH_W];
    slot_d.hrem   = REM_W'(hnum);
    slot_d.hdiv   = {dlt, {(DIV_STEPS-1){1'b0}}};
    slot_d.hq     = '0;
    slot_d.srem   = snum;
    slot_d.sdiv   = {mx, {(DIV_STEPS-1){1'b0}}};
    slot_d.sq     = '0;
    slot_d.val    = mx;
    slot_d.alpha  = alpha_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (en_i) begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rthsv_div_step.sv
// One restoring-division stage: one quotient bit for hue and for saturation.
`default_nettype none

module rthsv_div_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  rthsv_pkg::slot_t  slot_i,
  output rthsv_pkg::slot_t  slot_o
);
  import rthsv_pkg::*;

  logic  hge, sge;
  slot_t slot_d, slot_q;

  always_comb begin
    // divisor comes in shifted so the top quotient bit is resolved first
    hge = slot_i.hrem >= REM_W'(slot_i.hdiv);
    sge = slot_i.srem >= REM_W'(slot_i.sdiv);

    slot_d      = slot_i;
    slot_d.hrem = hge ? slot_i.hrem - REM_W'(slot_i.hdiv) : slot_i.hrem;
    slot_d.srem = sge ? slot_i.srem - REM_W'(slot_i.sdiv) : slot_i.srem;
    slot_d.hq   = {slot_i.hq[DIV_STEPS-2:0], hge};
    slot_d.sq   = {slot_i.sq[DIV_STEPS-2:0], sge};
    slot_d.hdiv = slot_i.hdiv >> 1;
    slot_d.sdiv = slot_i.sdiv >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (en_i) begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rgb_to_hsv_converter.sv
// Pipeline registers in order: setup, 8 divide stages, output.
// One pixel per clock unless stalled; both 8-stage restoring dividers are fully pipelined.
// The whole pipe advances when the output register is empty or being taken.
// Reset clears the stage registers and the output valid; no words are in flight after reset.
// Input ready follows output ready combinationally through the advance enable.
`default_nettype none

module rgb_to_hsv_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // red, green, blue, alpha_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // hue, saturation, brightness, alpha_out
);
  import rthsv_pkg::*;

  logic            adv;
  slot_t           slots [DIV_STEPS+1];
  slot_t           last;
  logic [CH_W-1:0] hue_d, sat_d, hq8, sq8;
  logic            out_vld_q;
  logic [31:0]     out_data_q;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  rthsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (s_axis_tvalid_i),
    .red_i   (s_axis_tdata_i[7:0]),
    .green_i (s_axis_tdata_i[15:8]),
    .blue_i  (s_axis_tdata_i[23:16]),
    .alpha_i (s_axis_tdata_i[31:24]),
    .slot_o  (slots[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rthsv_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .slot_i (slots[i]),
      .slot_o (slots[i+1])
    );
  end

  assign last = slots[DIV_STEPS];
  assign hq8  = CH_W'(last.hq);
  assign sq8  = CH_W'(last.sq);

  always_comb begin
    unique case (last.sector)
      SECT_GREY:  hue_d = '0;
      SECT_RED:   hue_d = (last.neg && hq8 != '0) ? CH_MAX - hq8 : hq8;
      SECT_GREEN: hue_d = last.neg ? HUE_OFS_G - hq8 : HUE_OFS_G + hq8;
      SECT_BLUE:  hue_d = last.neg ? HUE_OFS_B - hq8 : HUE_OFS_B + hq8;
      default:    hue_d = '0;
    endcase
    // black pixel: divisor was zero, quotient is meaningless
    sat_d = (last.val == '0) ? '0 : sq8;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {last.alpha, last.val, sat_d, hue_d};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  a_valid_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (m_axis_tvalid_o == $past(last.vld)))
    else $error("output valid does not follow last divider stage");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("output word changed while stalled");

  a_hue_quot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last.vld && last.sector != SECT_GREY) |-> (hq8 <= CH_W'(HUE_STEP)))
    else $error("hue quotient out of range");

  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[15:8] == '0) |-> (m_axis_tdata_o[7:0] == '0))
    else $error("zero saturation with nonzero hue");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the RGBA to HSVA stream converter.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rthsv_pkg::*;

  localparam time CLK_PERIOD  = 10ns;
  localparam int  RAND_PIXELS = 1200;
  localparam int  TAIL_CYCLES = 24;
  localparam int  MAX_REPORTS = 10;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgba_t;

  typedef struct packed {
    logic [CH_W-1:0] alpha_out;
    logic [CH_W-1:0] brightness;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] hue;
  } hsv_t;

  class hsv_scoreboard;
    hsv_t expected_q[$];
    int   mismatches;

    static function hsv_t predict_hsv(rgba_t px);
      int      r, g, b, mx, mn, d, h, s;
      sector_e sect;
      hsv_t    res;
      r  = int'(px.red);
      g  = int'(px.green);
      b  = int'(px.blue);
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      d  = mx - mn;
      // red wins ties over green, green over blue
      if (d == 0)       sect = SECT_GREY;
      else if (mx == r) sect = SECT_RED;
      else if (mx == g) sect = SECT_GREEN;
      else              sect = SECT_BLUE;
      // int division truncates toward zero
      case (sect)
        SECT_RED:   h = (int'(HUE_STEP) * (g - b)) / d;
        SECT_GREEN: h = int'(HUE_OFS_G) + (int'(HUE_STEP) * (b - r)) / d;
        SECT_BLUE:  h = int'(HUE_OFS_B) + (int'(HUE_STEP) * (r - g)) / d;
        default:    h = 0;
      endcase
      if (h < 0) h = int'(CH_MAX) + h;
      s = (mx != 0) ? (d * int'(CH_MAX)) / mx : 0;
      res.hue        = h[CH_W-1:0];
      res.saturation = s[CH_W-1:0];
      res.brightness = mx[CH_W-1:0];
      res.alpha_out  = px.alpha;
      return res;
    endfunction

    function void note_pixel(rgba_t px);
      expected_q.push_back(predict_hsv(px));
    endfunction

    function void check_result(hsv_t got);
      hsv_t exp_w;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected output word %h", $realtime, got);
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.hue != exp_w.hue || got.saturation != exp_w.saturation ||
          got.brightness != exp_w.brightness || got.alpha_out != exp_w.alpha_out) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: h/s/v/a expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d", $realtime,
                   exp_w.hue, exp_w.saturation, exp_w.brightness, exp_w.alpha_out,
                   got.hue, got.saturation, got.brightness, got.alpha_out);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data  = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;

  hsv_scoreboard sb;
  int            src_quiet;
  int            snk_quiet;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  rgb_to_hsv_converter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Random wait before each word, with occasional stretches of back-to-back words.
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet = $urandom_range(10, 40);
    return $urandom_range(0, 7);
  endfunction

  function automatic rgba_t mk_px(int r, int g, int b, int a);
    rgba_t px;
    px.red   = r[CH_W-1:0];
    px.green = g[CH_W-1:0];
    px.blue  = b[CH_W-1:0];
    px.alpha = a[CH_W-1:0];
    return px;
  endfunction

  task automatic send_pixel(rgba_t px);
    int gap;
    gap = draw_wait(src_quiet);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= px;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_pixel(px);
  endtask

  function automatic rgba_t rand_pixel();
    int r, g, b, lo, hi;
    r = $urandom_range(0, 255);
    g = $urandom_range(0, 255);
    b = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      5: begin  // grey
        g = r;
        b = r;
      end
      6: begin  // two channels share the max
        hi = $urandom_range(1, 255);
        lo = $urandom_range(0, hi);
        case ($urandom_range(0, 2))
          0: begin r = hi; g = hi; b = lo; end
          1: begin r = lo; g = hi; b = hi; end
          default: begin r = hi; g = lo; b = hi; end
        endcase
      end
      7: begin  // channel extremes
        r = $urandom_range(0, 1) ? 255 : 0;
        g = $urandom_range(0, 1) ? 255 : 0;
        b = $urandom_range(0, 1) ? 255 : $urandom_range(0, 255);
      end
      8: begin  // tiny values
        r = $urandom_range(0, 3);
        g = $urandom_range(0, 3);
        b = $urandom_range(0, 3);
      end
      9: begin  // small spread
        lo = $urandom_range(0, 250);
        r  = lo + $urandom_range(0, 5);
        g  = lo + $urandom_range(0, 5);
        b  = lo + $urandom_range(0, 5);
      end
      default: ;
    endcase
    return mk_px(r, g, b, $urandom_range(0, 255));
  endfunction

  // Result side: stall before each word, then hold ready until one is taken.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(snk_quiet);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) sb.check_result(m_axis_tdata_o);
  end

  initial begin
    sb        = new();
    src_quiet = 0;
    snk_quiet = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(mk_px(0, 0, 0, 0));            // black
    send_pixel(mk_px(255, 255, 255, 255));    // white
    send_pixel(mk_px(128, 128, 128, 8'h5A));  // grey
    send_pixel(mk_px(255, 0, 0, 8'hA5));
    send_pixel(mk_px(0, 255, 0, 8'h0F));
    send_pixel(mk_px(0, 0, 255, 8'hF0));
    send_pixel(mk_px(255, 255, 0, 1));        // red/green tie
    send_pixel(mk_px(0, 255, 255, 254));      // green/blue tie
    send_pixel(mk_px(255, 0, 255, 8'h80));    // red/blue tie, negative hue
    send_pixel(mk_px(200, 10, 100, 8'h7F));   // negative hue
    send_pixel(mk_px(255, 1, 254, 3));
    send_pixel(mk_px(255, 254, 0, 8'hC3));
    send_pixel(mk_px(1, 0, 0, 8'h3C));
    send_pixel(mk_px(10, 9, 9, 8'h55));
    send_pixel(mk_px(0, 1, 2, 8'hAA));
    send_pixel(mk_px(200, 100, 50, 8'h11));
    send_pixel(mk_px(50, 200, 100, 8'h22));
    send_pixel(mk_px(100, 50, 200, 8'h44));
    send_pixel(mk_px(254, 255, 1, 8'h88));
    send_pixel(mk_px(85, 170, 255, 8'hEE));
    send_pixel(mk_px(1, 1, 0, 8'hDD));
    send_pixel(mk_px(0, 0, 1, 8'hBB));

    repeat (RAND_PIXELS) send_pixel(rand_pixel());
    s_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/rthsv_pkg.sv
hw/rtl/rthsv_prep.sv
hw/rtl/rthsv_div_step.sv
hw/rtl/rgb_to_hsv_converter.sv
tb/testbench.sv
